/* hw/rtl/mbc_pkg.sv */
// Package: shared constants and types for the multi-button click classifier.
`timescale 1ns / 1ps

package mbc_pkg;

    localparam int BUTTONS    = 4;
    localparam int PIN_W      = 4;
    localparam int LED_W      = 8;
    localparam int CLEAN_W    = 4;
    localparam int HI_OFFSET  = 4;
    localparam int DB_W       = 3;
    localparam int TICK_W     = 8;
    localparam int CLICK_W    = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W  = 8;
    localparam int RES_W      = LED_W + LED_W + CLEAN_W;
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

    localparam int TOG_WIDE_W = BUTTONS + HI_OFFSET + LED_W;
    localparam int CLN_WIDE_W = BUTTONS + CLEAN_W;
    localparam int PIN_WIDE_W = BUTTONS + PIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP = 2'd2;

    localparam logic [DB_W-1:0]    DEBOUNCE_RST   = 3'd3;
    localparam logic [TICK_W-1:0]  LONG_PRESS_RST = 8'd30;
    localparam logic [TICK_W-1:0]  CLICK_GAP_RST  = 8'd15;

    localparam logic [DB_W-1:0]    CHANGE_MAX = '1;
    localparam logic [TICK_W-1:0]  TICK_MAX   = '1;
    localparam logic [CLICK_W-1:0] CLICK_MAX  = '1;
    localparam logic [CLICK_W-1:0] CLICK_ONE  = 2'd1;
    localparam logic [CLICK_W-1:0] CLICK_TWO  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_WAITING = 2'd2
    } phase_t;

    typedef struct packed {
        logic level;
        logic tog_lo;
        logic tog_hi;
    } lane_out_t;

endpackage

/* hw/rtl/mbc_lane.sv */
// Per-button lane: debounce counter and click phase machine.
`timescale 1ns / 1ps

module mbc_lane (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         tick_en,
    input  logic                         raw,
    input  logic [mbc_pkg::DB_W-1:0]     debounce_ticks,
    input  logic [mbc_pkg::TICK_W-1:0]   long_press_ticks,
    input  logic [mbc_pkg::TICK_W-1:0]   click_gap_ticks,
    output mbc_pkg::lane_out_t           lane_out
);
    import mbc_pkg::*;

    logic               level_reg,  level_next;
    logic [DB_W-1:0]    change_reg, change_next;
    phase_t             phase_reg,  phase_next;
    logic [TICK_W-1:0]  held_reg,   held_next;
    logic [CLICK_W-1:0] click_reg,  click_next;
    logic [DB_W-1:0]    change_inc;
    logic               tog_lo, tog_hi;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= 1'b1;
            change_reg <= '0;
            phase_reg  <= PH_IDLE;
            held_reg   <= '0;
            click_reg  <= '0;
        end else if (tick_en) begin
            level_reg  <= level_next;
            change_reg <= change_next;
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            click_reg  <= click_next;
        end
    end

    always_comb begin
        held_next   = held_reg;
        click_next  = click_reg;
        phase_next  = phase_reg;
        level_next  = level_reg;
        change_next = '0;
        change_inc  = change_reg;
        tog_lo      = 1'b0;
        tog_hi      = 1'b0;

        if (phase_reg != PH_IDLE && held_reg != TICK_MAX) begin
            held_next = held_reg + 1'b1;
        end

        if (level_reg != raw) begin
            if (change_reg != CHANGE_MAX) begin
                change_inc = change_reg + 1'b1;
            end
            if (change_inc >= debounce_ticks) begin
                level_next  = raw;
                change_next = '0;
            end else begin
                change_next = change_inc;
            end
        end

        case (phase_reg)
            PH_IDLE: begin
                if (!level_next) begin
                    held_next  = '0;
                    click_next = CLICK_ONE;
                    phase_next = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (level_next) begin
                    if (held_next >= long_press_ticks) begin
                        tog_lo     = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        held_next  = '0;
                        phase_next = PH_WAITING;
                    end
                end else if (held_next >= long_press_ticks) begin
                    click_next = '0;
                end
            end
            PH_WAITING: begin
                if (held_next >= click_gap_ticks) begin
                    phase_next = PH_IDLE;
                    if (click_reg == CLICK_ONE) begin
                        tog_hi = 1'b1;
                    end else if (click_reg == CLICK_TWO) begin
                        tog_lo = 1'b1;
                    end
                end else if (!level_next) begin
                    if (click_reg != CLICK_MAX) begin
                        click_next = click_reg + 1'b1;
                    end
                    held_next  = '0;
                    phase_next = PH_PRESSED;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign lane_out.level  = level_next;
    assign lane_out.tog_lo = tog_lo;
    assign lane_out.tog_hi = tog_hi;

endmodule

/* hw/rtl/mbc_merge.sv */
// Merge stage: combines lane toggles, holds the LED register and the output skid buffer.
`timescale 1ns / 1ps

module mbc_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick_en,
    input  mbc_pkg::lane_out_t            lanes [mbc_pkg::BUTTONS],
    output logic                          skid_full,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbc_pkg::M_TDATA_W-1:0] m_tdata
);
    import mbc_pkg::*;

    logic [BUTTONS-1:0]    lo_vec, hi_vec, lvl_vec;
    logic [TOG_WIDE_W-1:0] tog_wide;
    logic [CLN_WIDE_W-1:0] cln_wide;
    logic [LED_W-1:0]      toggles;
    logic [CLEAN_W-1:0]    clean;
    logic [LED_W-1:0]      led_reg, led_next;
    logic [RES_W-1:0]      result;
    logic [RES_W-1:0]      out_reg, skid_reg;
    logic                  out_valid_reg, skid_valid_reg;

    always_comb begin
        for (int i = 0; i < BUTTONS; i++) begin
            lo_vec[i]  = lanes[i].tog_lo;
            hi_vec[i]  = lanes[i].tog_hi;
            lvl_vec[i] = lanes[i].level;
        end
    end

    assign tog_wide = TOG_WIDE_W'(lo_vec) ^ (TOG_WIDE_W'(hi_vec) << HI_OFFSET);
    assign toggles  = tog_wide[LED_W-1:0];
    assign cln_wide = CLN_WIDE_W'(lvl_vec);
    assign clean    = cln_wide[CLEAN_W-1:0];
    assign led_next = led_reg ^ toggles;
    assign result   = {clean, toggles, led_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (tick_en) begin
                led_reg <= led_next;
            end
            if (!out_valid_reg || m_tready) begin
                out_valid_reg  <= skid_valid_reg || tick_en;
                skid_valid_reg <= 1'b0;
            end else if (tick_en) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end else if (tick_en) begin
            skid_reg <= result;
        end
    end

    assign skid_full = skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_reg);

endmodule

/* hw/rtl/multi_button_click_classifier_top.sv */
// Top level: four-button debounce and single/double/long press classifier.
`timescale 1ns / 1ps

// Each accepted pin sample yields exactly one result transaction; every button
// lane updates in the same cycle, so throughput is one transaction per cycle
// while s_tready is high, and results leave through the output register. A
// two-deep output buffer lets input continue while a result waits; s_tready
// drops only when both entries are occupied. Configuration writes take effect
// at the next accepted sample and should be issued while the stream is idle.
module multi_button_click_classifier_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] pin_levels
    input  logic [mbc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] led_bits, [15:8] toggle_mask, [19:16] clean_levels
    output logic [mbc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  logic [mbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mbc_pkg::*;

    logic [DB_W-1:0]       debounce_reg;
    logic [TICK_W-1:0]     long_press_reg;
    logic [TICK_W-1:0]     click_gap_reg;
    logic                  tick_en;
    logic                  skid_full;
    logic [PIN_WIDE_W-1:0] pin_wide;
    lane_out_t             lanes [BUTTONS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
            click_gap_reg  <= CLICK_GAP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_wdata[DB_W-1:0];
                REG_LONG_PRESS: long_press_reg <= cfg_wdata[TICK_W-1:0];
                REG_CLICK_GAP:  click_gap_reg  <= cfg_wdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !skid_full;
    assign tick_en  = s_tvalid && s_tready;
    assign pin_wide = PIN_WIDE_W'(s_tdata[PIN_W-1:0]);

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        mbc_lane u_lane (
            .aclk             (aclk),
            .aresetn          (aresetn),
            .tick_en          (tick_en),
            .raw              (pin_wide[g]),
            .debounce_ticks   (debounce_reg),
            .long_press_ticks (long_press_reg),
            .click_gap_ticks  (click_gap_reg),
            .lane_out         (lanes[g])
        );
    end

    mbc_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (tick_en),
        .lanes     (lanes),
        .skid_full (skid_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
